[sv/vlc_pkg.sv]
package vlc_pkg;

	localparam int unsigned VALUE_W    = 64;
	localparam int unsigned NARROW_W   = 32;
	localparam int unsigned GROUP_BITS = 7;
	localparam int unsigned MAX_GROUPS = 10;
	localparam int unsigned GRP_IDX_W  = 4;
	localparam int unsigned POS_W      = 7;

	localparam logic [7:0] GROUP_MASK = 8'h7F;
	localparam logic [7:0] CONT_BIT   = 8'h80;

	localparam logic OP_ENCODE   = 1'b0;
	localparam logic OP_DECODE   = 1'b1;
	localparam logic KIND_BYTE   = 1'b0;
	localparam logic KIND_VALUE  = 1'b1;

	typedef struct packed {
		logic        op;
		logic [63:0] value_in;
		logic [7:0]  byte_in;
	} in_item_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  byte_out;
		logic        last;
		logic [63:0] value_out;
		logic        overflow;
	} out_item_t;

	// Encoder status toward the output stage.
	typedef struct packed {
		logic       busy;
		logic [7:0] code;
		logic       last;
	} enc_stat_t;

	// Finished decode result waiting for the output stage.
	typedef struct packed {
		logic        valid;
		logic [63:0] value;
		logic        overflow;
	} dec_res_t;

endpackage

[sv/varint_codec.sv]
// Encode: one value goes out as n bytes (1 to 10). The accepted value is loaded
// into the encoder's shift register, and each byte then moves to the output register,
// one byte per cycle while out_ready is high, paced by the encoder's shift register, which
// drops one 7-bit group per beat.
// Decode: a byte with the continuation bit updates the decoder state and yields nothing;
// the final byte's value passes through the decoder's result register to the output register.
// Reset clears wide_q, the decode accumulator and all valid flags.
module varint_codec (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  vlc_pkg::in_item_t  in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output vlc_pkg::out_item_t out_data,
	input  logic               cfg_we,
	input  logic               cfg_data
);

	logic                wide_q;
	logic                out_valid_q;
	vlc_pkg::out_item_t  out_data_q;
	vlc_pkg::enc_stat_t  enc_st;
	vlc_pkg::dec_res_t   dec_res;

	logic in_acc;
	logic slot_free;
	logic enc_take;
	logic dec_take;

	assign in_ready  = !enc_st.busy && !dec_res.valid;
	assign in_acc    = in_valid && in_ready;
	assign slot_free = !out_valid_q || out_ready;
	assign enc_take  = enc_st.busy && slot_free;
	assign dec_take  = dec_res.valid && slot_free;

	vlc_encoder u_enc (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (in_acc && in_data.op == vlc_pkg::OP_ENCODE),
		.value  (in_data.value_in),
		.wide   (wide_q),
		.take   (enc_take),
		.stat   (enc_st)
	);

	vlc_decoder u_dec (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (in_acc && in_data.op == vlc_pkg::OP_DECODE),
		.code   (in_data.byte_in),
		.wide   (wide_q),
		.take   (dec_take),
		.res    (dec_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				wide_q <= cfg_data;
			end
			if (slot_free) begin
				out_valid_q <= enc_st.busy || dec_res.valid;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (enc_take) begin
			out_data_q.kind      <= vlc_pkg::KIND_BYTE;
			out_data_q.byte_out  <= enc_st.code;
			out_data_q.last      <= enc_st.last;
			out_data_q.value_out <= '0;
			out_data_q.overflow  <= 1'b0;
		end else if (dec_take) begin
			out_data_q.kind      <= vlc_pkg::KIND_VALUE;
			out_data_q.byte_out  <= '0;
			out_data_q.last      <= 1'b0;
			out_data_q.value_out <= dec_res.value;
			out_data_q.overflow  <= dec_res.overflow;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_one_source: assert property (@(posedge clk) disable iff (!arst_n)
		!(enc_st.busy && dec_res.valid))
		else $error("encoder and decoder both hold a beat");

endmodule

[sv/vlc_encoder.sv]
module vlc_encoder (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                load,
	input  logic [63:0]         value,
	input  logic                wide,
	input  logic                take,
	output vlc_pkg::enc_stat_t  stat
);

	logic        busy_q;
	logic [63:0] shift_q;
	logic        cont;

	// More bytes follow while anything remains above the current group.
	assign cont = |shift_q[vlc_pkg::VALUE_W-1:vlc_pkg::GROUP_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && !cont) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			shift_q <= wide ? value : {32'd0, value[vlc_pkg::NARROW_W-1:0]};
		end else if (take) begin
			shift_q <= shift_q >> vlc_pkg::GROUP_BITS;
		end
	end

	assign stat.busy = busy_q;
	assign stat.code = (shift_q[7:0] & vlc_pkg::GROUP_MASK) | (cont ? vlc_pkg::CONT_BIT : 8'h00);
	assign stat.last = !cont;

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && take && !cont && !load |=> !busy_q)
		else $error("encoder still busy after its last beat");

	a_no_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !busy_q)
		else $error("encoder loaded while a value is still going out");

endmodule

[sv/vlc_decoder.sv]
module vlc_decoder (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [7:0]        code,
	input  logic              wide,
	input  logic              take,
	output vlc_pkg::dec_res_t res
);

	logic [63:0] acc_q;
	logic [vlc_pkg::GRP_IDX_W-1:0] grp_q;
	logic        ovf_q;
	logic        res_valid_q;
	logic [63:0] res_value_q;
	logic        res_ovf_q;

	logic [63:0] acc_n;
	logic [63:0] mask;
	logic        ovf_n;
	logic [vlc_pkg::POS_W-1:0] base;
	logic [vlc_pkg::POS_W-1:0] pos;
	logic [vlc_pkg::POS_W-1:0] limit;
	logic [6:0]  grp;

	assign grp   = code[6:0];
	assign mask  = wide ? '1 : {32'd0, 32'hFFFF_FFFF};
	assign base  = vlc_pkg::POS_W'(grp_q) * vlc_pkg::POS_W'(vlc_pkg::GROUP_BITS);
	assign limit = wide ? vlc_pkg::POS_W'(vlc_pkg::VALUE_W) : vlc_pkg::POS_W'(vlc_pkg::NARROW_W);

	// Each accumulator bit belongs to one fixed group slot; only the slot of the
	// current group is written.
	always_comb begin
		acc_n = acc_q;
		for (int i = 0; i < 64; i++) begin
			if (grp_q == vlc_pkg::GRP_IDX_W'(i / 7) && mask[i]) begin
				acc_n[i] = acc_q[i] | grp[i % 7];
			end
		end
	end

	always_comb begin
		ovf_n = ovf_q;
		pos   = base;
		for (int j = 0; j < 7; j++) begin
			pos = base + vlc_pkg::POS_W'(j);
			if (grp[j] && pos >= limit) begin
				ovf_n = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			grp_q       <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (take) begin
				res_valid_q <= 1'b0;
			end
			if (step) begin
				if (code[7]) begin
					acc_q <= acc_n;
					ovf_q <= ovf_n;
					if (grp_q < vlc_pkg::GRP_IDX_W'(vlc_pkg::MAX_GROUPS)) begin
						grp_q <= grp_q + 1'b1;
					end
				end else begin
					acc_q       <= '0;
					grp_q       <= '0;
					ovf_q       <= 1'b0;
					res_valid_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && !code[7]) begin
			res_value_q <= acc_n & mask;
			res_ovf_q   <= ovf_n;
		end
	end

	assign res.valid    = res_valid_q;
	assign res.value    = res_value_q;
	assign res.overflow = res_ovf_q;

	a_final_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && !code[7] |=> grp_q == '0 && acc_q == '0 && !ovf_q && res_valid_q)
		else $error("decode state not cleared after the final byte");

	a_res_holds: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid_q && !take |=> res_valid_q)
		else $error("decode result dropped before it was taken");

endmodule

[tb/tb.sv]
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT   = 3000;
	localparam int SETTLE_CYCLES = 8;
	localparam int TAIL_CYCLES   = 12;
	localparam int PHASE_ITEMS   = 46;
	localparam int NUM_PHASES    = 4;
	localparam logic [6:0] POS_CAP = 7'(vlc_pkg::GROUP_BITS * vlc_pkg::MAX_GROUPS);

	typedef struct {
		bit                 is_cfg;
		bit                 wide;
		vlc_pkg::in_item_t  item;
		bit                 has_typed;
		vlc_pkg::out_item_t typed;
	} row_t;

	logic               clk       = 1'b0;
	logic               arst_n    = 1'b0;
	logic               in_valid  = 1'b0;
	logic               out_ready = 1'b0;
	logic               cfg_we    = 1'b0;
	logic               cfg_data  = 1'b0;
	vlc_pkg::in_item_t  in_data   = '0;
	logic               in_ready;
	logic               out_valid;
	vlc_pkg::out_item_t out_data;

	// Mirror of the codec state and its width register.
	logic        wide_sel = 1'b0;
	logic [63:0] acc_bits = '0;
	logic [6:0]  grp_pos  = '0;
	logic        ovf_hit  = 1'b0;

	vlc_pkg::out_item_t leb_results[$];
	int        bad_cnt   = 0;
	bit        in_burst  = 1'b0;
	bit        out_burst = 1'b0;
	int        in_cnt    = 0;
	int        out_cnt   = 0;

	varint_codec u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void leb_apply(vlc_pkg::in_item_t it);
		logic [63:0]        mask;
		logic [63:0]        v;
		logic [6:0]         grp;
		int                 w;
		int                 s;
		vlc_pkg::out_item_t r;
		mask = wide_sel ? {vlc_pkg::VALUE_W{1'b1}} : (64'd1 << vlc_pkg::NARROW_W) - 64'd1;
		if (it.op == vlc_pkg::OP_ENCODE) begin
			v = it.value_in & mask;
			while (v > 64'(vlc_pkg::GROUP_MASK)) begin
				r = '0;
				r.kind = vlc_pkg::KIND_BYTE;
				r.byte_out = vlc_pkg::CONT_BIT | {1'b0, v[6:0]};
				leb_results.push_back(r);
				v = v >> vlc_pkg::GROUP_BITS;
			end
			r = '0;
			r.kind = vlc_pkg::KIND_BYTE;
			r.byte_out = {1'b0, v[6:0]};
			r.last = 1'b1;
			leb_results.push_back(r);
		end else begin
			grp = it.byte_in[6:0];
			w = wide_sel ? vlc_pkg::VALUE_W : vlc_pkg::NARROW_W;
			s = int'(grp_pos);
			// Groups that start past the width only matter when nonzero.
			if (s >= w) begin
				if (grp != 7'd0)
					ovf_hit = 1'b1;
			end else begin
				if (s + vlc_pkg::GROUP_BITS > w && (64'(grp) >> (w - s)) != 64'd0)
					ovf_hit = 1'b1;
				acc_bits = acc_bits | ((64'(grp) << s) & mask);
			end
			if (grp_pos < POS_CAP)
				grp_pos = grp_pos + 7'(vlc_pkg::GROUP_BITS);
			if ((it.byte_in & vlc_pkg::CONT_BIT) == 8'd0) begin
				r = '0;
				r.kind = vlc_pkg::KIND_VALUE;
				r.value_out = acc_bits & mask;
				r.overflow = ovf_hit;
				leb_results.push_back(r);
				acc_bits = '0;
				grp_pos = '0;
				ovf_hit = 1'b0;
			end
		end
	endfunction

	function automatic vlc_pkg::in_item_t enc_item(logic [63:0] value);
		vlc_pkg::in_item_t it;
		it.op = vlc_pkg::OP_ENCODE;
		it.value_in = value;
		it.byte_in = 8'($urandom);
		return it;
	endfunction

	function automatic vlc_pkg::in_item_t dec_item(logic [7:0] code);
		vlc_pkg::in_item_t it;
		it.op = vlc_pkg::OP_DECODE;
		it.value_in = {$urandom, $urandom};
		it.byte_in = code;
		return it;
	endfunction

	function automatic row_t mk_enc(logic [63:0] value, bit has_typed, logic [7:0] code);
		row_t row;
		row.is_cfg = 1'b0;
		row.wide = 1'b0;
		row.item = enc_item(value);
		row.has_typed = has_typed;
		row.typed = '0;
		row.typed.kind = vlc_pkg::KIND_BYTE;
		row.typed.byte_out = code;
		row.typed.last = 1'b1;
		return row;
	endfunction

	function automatic row_t mk_dec(logic [7:0] code, bit has_typed, logic [63:0] value,
			logic ovf);
		row_t row;
		row.is_cfg = 1'b0;
		row.wide = 1'b0;
		row.item = dec_item(code);
		row.has_typed = has_typed;
		row.typed = '0;
		row.typed.kind = vlc_pkg::KIND_VALUE;
		row.typed.value_out = value;
		row.typed.overflow = ovf;
		return row;
	endfunction

	function automatic row_t mk_cfg(bit wide);
		row_t row;
		row.is_cfg = 1'b1;
		row.wide = wide;
		row.item = '0;
		row.has_typed = 1'b0;
		row.typed = '0;
		return row;
	endfunction

	task automatic report_bad(string what, logic [63:0] want, logic [63:0] got);
		$display("%0t: mismatch on %s: want %h, got %h", $realtime, what, want, got);
		bad_cnt++;
	endtask

	// Where a row carries a typed result, it replaces what the mirror produced.
	task automatic send_item(vlc_pkg::in_item_t it, bit has_typed = 1'b0,
			vlc_pkg::out_item_t typed = '0);
		int gap;
		int n0;
		if (in_cnt % 16 == 0)
			in_burst = ($urandom_range(0, 3) == 0);
		in_cnt++;
		gap = in_burst ? 0 : $urandom_range(0, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		do @(posedge clk); while (!in_ready);
		n0 = leb_results.size();
		leb_apply(it);
		if (has_typed) begin
			while (leb_results.size() > n0)
				void'(leb_results.pop_back());
			leb_results.push_back(typed);
		end
	endtask

	// A continuation byte yields nothing, so keep waiting for SETTLE_CYCLES after the last result.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (leb_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_width(bit wide);
		cfg_we <= 1'b1;
		cfg_data <= wide;
		@(posedge clk);
		cfg_we <= 1'b0;
		wide_sel = wide;
	endtask

	always @(posedge clk) begin
		vlc_pkg::out_item_t w;
		if (arst_n && out_valid && out_ready) begin
			if (leb_results.size() == 0) begin
				report_bad("beat with nothing pending", '0, out_data.value_out);
			end else begin
				w = leb_results.pop_front();
				if (out_data.kind !== w.kind)
					report_bad("kind", 64'(w.kind), 64'(out_data.kind));
				if (out_data.byte_out !== w.byte_out)
					report_bad("byte_out", 64'(w.byte_out), 64'(out_data.byte_out));
				if (out_data.last !== w.last)
					report_bad("last", 64'(w.last), 64'(out_data.last));
				if (out_data.value_out !== w.value_out)
					report_bad("value_out", w.value_out, out_data.value_out);
				if (out_data.overflow !== w.overflow)
					report_bad("overflow", 64'(w.overflow), 64'(out_data.overflow));
			end
		end
	end

	initial begin
		int stall;
		@(posedge arst_n);
		forever begin
			if (out_cnt % 16 == 0)
				out_burst = ($urandom_range(0, 3) == 0);
			out_cnt++;
			stall = out_burst ? 0 : $urandom_range(0, 14);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!(out_valid && out_ready));
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		@(posedge arst_n);
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin
		row_t        rows[$];
		int          sent;
		int          n;
		int          r;
		logic [6:0]  grp;
		rows.push_back(mk_enc(64'd0, 1'b1, 8'h00));
		rows.push_back(mk_enc(64'h7F, 1'b1, 8'h7F));
		rows.push_back(mk_enc(64'h80, 1'b0, 8'h00));
		rows.push_back(mk_enc({64{1'b1}}, 1'b0, 8'h00));
		// Everything sits above the narrow width, so only a zero byte remains.
		rows.push_back(mk_enc(64'hFFFF_FFFF_0000_0000, 1'b1, 8'h00));
		rows.push_back(mk_dec(8'h00, 1'b1, 64'd0, 1'b0));
		rows.push_back(mk_dec(8'h7F, 1'b1, 64'h7F, 1'b0));
		repeat (4) rows.push_back(mk_dec(8'hFF, 1'b0, '0, 1'b0));
		rows.push_back(mk_dec(8'h0F, 1'b1, 64'hFFFF_FFFF, 1'b0));
		repeat (4) rows.push_back(mk_dec(8'h80, 1'b0, '0, 1'b0));
		rows.push_back(mk_dec(8'h10, 1'b1, 64'd0, 1'b1));
		// An encode in the middle of a decode leaves the partial value alone.
		rows.push_back(mk_dec(8'h81, 1'b0, '0, 1'b0));
		rows.push_back(mk_enc(64'd5, 1'b1, 8'h05));
		rows.push_back(mk_dec(8'h01, 1'b1, 64'h81, 1'b0));
		rows.push_back(mk_cfg(1'b1));
		rows.push_back(mk_enc({64{1'b1}}, 1'b0, 8'h00));
		rows.push_back(mk_enc(64'h8000_0000_0000_0000, 1'b0, 8'h00));
		// The width drops to 32 bits between the two bytes of one value.
		rows.push_back(mk_dec(8'h85, 1'b0, '0, 1'b0));
		rows.push_back(mk_cfg(1'b0));
		rows.push_back(mk_dec(8'h02, 1'b1, 64'h105, 1'b0));

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[i]) begin
			if (rows[i].is_cfg) begin
				wait_idle();
				set_width(rows[i].wide);
			end else begin
				send_item(rows[i].item, rows[i].has_typed, rows[i].typed);
			end
		end

		sent = 0;
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			set_width(ph % 2 == 0);
			while (sent < PHASE_ITEMS * (ph + 1)) begin
				r = $urandom_range(0, 99);
				if (r < 35) begin
					send_item(enc_item({$urandom, $urandom} >> $urandom_range(0, 63)));
					sent++;
				end else if (r < 80) begin
					// Well-formed byte run; now and then longer than the narrow width allows.
					if ($urandom_range(0, 5) == 0)
						n = $urandom_range(6, 13);
					else
						n = $urandom_range(1, wide_sel ? 10 : 5);
					for (int i = 0; i < n; i++) begin
						grp = 7'($urandom_range(0, 127) >> $urandom_range(0, 6));
						send_item(dec_item({i < n - 1, grp}));
						sent++;
					end
				end else if (r < 83) begin
					wait_idle();
				end else begin
					send_item(dec_item(8'($urandom_range(0, 255))));
					sent++;
				end
			end
		end

		in_valid <= 1'b0;
		while (leb_results.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (bad_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

[files.f]
sv/vlc_pkg.sv
sv/vlc_encoder.sv
sv/vlc_decoder.sv
sv/varint_codec.sv
tb/tb.sv
